### rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Short forms for clocked concurrent assertions used by the checkers.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is high
`define TT_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that is checked during reset as well
`define TT_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/txttok_pkg.sv
// ---------------------------------------------------------------------------
// Text tokenizer package
// Shared types, codes and character constants of the tokenizer.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package txttok_pkg;

   // Widths of the result fields, result count and queue depth
   localparam int TEXT_W      = 16;
   localparam int MAX_RES     = 3;
   localparam int RES_IDX_W   = 2;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = 2;

   // Characters with a meaning of their own
   localparam logic [7:0] CHR_SLASH  = 8'h2F;
   localparam logic [7:0] CHR_LF     = 8'h0A;
   localparam logic [7:0] CHR_QUOTE  = 8'h22;
   localparam logic [7:0] CHR_LPAREN = 8'h28;
   localparam logic [7:0] CHR_RPAREN = 8'h29;
   localparam logic [7:0] CHR_SPACE  = 8'h20;
   localparam logic [7:0] CHR_TAB    = 8'h09;
   localparam logic [7:0] CHR_CR     = 8'h0D;

   // Configuration register indexes
   localparam logic [1:0] CSR_SPLIT_LOW  = 2'd0;
   localparam logic [1:0] CSR_SPLIT_HIGH = 2'd1;
   localparam logic [1:0] CSR_QUOTES_EN  = 2'd2;
   localparam logic [1:0] CSR_PARENS_EN  = 2'd3;

   typedef enum logic [1:0] {
      EV_TOKEN        = 2'd0,
      EV_UNCLOSED_EOI = 2'd1,
      EV_UNCLOSED_EOL = 2'd2,
      EV_END          = 2'd3
   } event_type;

   typedef enum logic [1:0] {
      KIND_WORD  = 2'd0,
      KIND_SPLIT = 2'd1,
      KIND_QUOTE = 2'd2,
      KIND_PAREN = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      MODE_BETWEEN = 3'd0,
      MODE_WORD    = 3'd1,
      MODE_SLASH   = 3'd2,
      MODE_COMMENT = 3'd3,
      MODE_QUOTE   = 3'd4
   } mode_type;

   // One result item
   typedef struct packed {
      event_type         ev;
      kind_type          kind;
      logic [TEXT_W-1:0] start;
      logic [TEXT_W-1:0] len;
      logic [TEXT_W-1:0] line;
   } res_type;

   // All results caused by one input byte
   typedef struct packed {
      logic [RES_IDX_W-1:0]        cnt;
      res_type [MAX_RES-1:0]       res;
   } bundle_type;

   // Front to queue
   typedef struct packed {
      logic       valid;
      bundle_type bundle;
   } push_type;

   // Queue head to back
   typedef struct packed {
      logic       valid;
      bundle_type bundle;
   } head_type;

endpackage

### rtl/txttok_front.sv
// ---------------------------------------------------------------------------
// Tokenizer front end
// Holds the configuration, scans one byte per cycle while the queue has space
// and packs the results that the byte causes into one bundle for the queue.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module txttok_front import txttok_pkg::*; #(
   parameter int POSITION_BITS = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_we,
   input  logic [1:0]           csr_index,
   input  logic [63:0]          csr_wdata,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [7:0]           req_in_byte,
   input  logic                 req_end_of_input,
   input  logic                 push_space,
   output push_type             push
);

   localparam logic [POSITION_BITS-1:0] POS_ONE = POSITION_BITS'(1);

   logic [63:0]              mask_lo_ff, mask_hi_ff;
   logic                     quote_en_ff, paren_en_ff;
   mode_type                 mode_ff, mode_a, mode_in;
   logic [POSITION_BITS-1:0] pos_ff, pos_in, pos_inc;
   logic [POSITION_BITS-1:0] pstart_ff, pstart_a, pstart_in;
   logic [POSITION_BITS-1:0] nl_ff, nl_a, nl_in;
   logic                     paren_ff, paren_a, paren_in;

   logic                     accept;
   logic [7:0]               c;
   logic                     is_sp, is_spl, delim, split_slash, open_ok;
   logic [7:0]               closer;
   kind_type                 kind_q, kind_e;
   logic                     close_word, slash_split, slash_comment, slash_word;
   logic                     quote_close, quote_eol, comment_eol, idle_mode, restart;
   logic                     start_slash, start_open, start_space, start_split, start_word;
   res_type [MAX_RES-1:0]    res;
   logic [RES_IDX_W-1:0]     n;

   function automatic logic [POSITION_BITS-1:0] sat_inc(input logic [POSITION_BITS-1:0] v);
      sat_inc = (v == '1) ? v : v + POS_ONE;
   endfunction

   function automatic res_type mk_res(input event_type ev, input kind_type kind,
                                      input logic [POSITION_BITS-1:0] start,
                                      input logic [POSITION_BITS-1:0] len,
                                      input logic [POSITION_BITS-1:0] line);
      mk_res.ev    = ev;
      mk_res.kind  = kind;
      mk_res.start = TEXT_W'(start);
      mk_res.len   = TEXT_W'(len);
      mk_res.line  = TEXT_W'(line);
   endfunction

   assign accept    = req_valid & req_ready;
   assign req_ready = push_space;
   assign c         = req_in_byte;

   // Classify the byte
   always_comb begin
      is_sp       = (c == CHR_SPACE) || ((c >= CHR_TAB) && (c <= CHR_CR));
      is_spl      = !c[7] && (c[6] ? mask_hi_ff[c[5:0]] : mask_lo_ff[c[5:0]]);
      delim       = is_sp | is_spl;
      split_slash = mask_lo_ff[CHR_SLASH[5:0]];
      open_ok     = (quote_en_ff && (c == CHR_QUOTE)) || (paren_en_ff && (c == CHR_LPAREN));
      closer      = paren_ff ? CHR_RPAREN : CHR_QUOTE;
      kind_q      = paren_ff ? KIND_PAREN : KIND_QUOTE;
   end

   // Decide what the byte does in the current mode
   always_comb begin
      close_word    = delim && ((mode_ff == MODE_WORD) ||
                      ((mode_ff == MODE_SLASH) && (c != CHR_SLASH) && !split_slash));
      slash_split   = (mode_ff == MODE_SLASH) && (c != CHR_SLASH) && split_slash;
      slash_comment = (mode_ff == MODE_SLASH) && (c == CHR_SLASH);
      slash_word    = (mode_ff == MODE_SLASH) && (c != CHR_SLASH) && !split_slash && !delim;
      quote_close   = (mode_ff == MODE_QUOTE) && (c == closer);
      quote_eol     = (mode_ff == MODE_QUOTE) && (c != closer) && (c == CHR_LF);
      comment_eol   = (mode_ff == MODE_COMMENT) && (c == CHR_LF);
      idle_mode     = (mode_ff != MODE_WORD) && (mode_ff != MODE_SLASH) &&
                      (mode_ff != MODE_COMMENT) && (mode_ff != MODE_QUOTE);
      restart       = close_word | slash_split | quote_eol | comment_eol | idle_mode;
      start_slash   = restart && (c == CHR_SLASH);
      start_open    = restart && (c != CHR_SLASH) && open_ok;
      start_space   = restart && (c != CHR_SLASH) && !open_ok && is_sp;
      start_split   = restart && (c != CHR_SLASH) && !open_ok && !is_sp && is_spl;
      start_word    = restart && (c != CHR_SLASH) && !open_ok && !is_sp && !is_spl;
   end

   // Next scan state
   always_comb begin
      mode_a   = mode_ff;
      pstart_a = pstart_ff;
      paren_a  = paren_ff;
      nl_a     = nl_ff;
      if (slash_comment) begin
         mode_a = MODE_COMMENT;
      end
      if (slash_word) begin
         mode_a = MODE_WORD;
      end
      if (quote_close || restart) begin
         mode_a = MODE_BETWEEN;
      end
      if (start_slash) begin
         mode_a   = MODE_SLASH;
         pstart_a = pos_ff;
      end
      if (start_open) begin
         mode_a   = MODE_QUOTE;
         paren_a  = (c == CHR_LPAREN);
         pstart_a = sat_inc(pos_ff);
      end
      if (start_space && (c == CHR_LF)) begin
         nl_a = sat_inc(nl_ff);
      end
      if (start_word) begin
         mode_a   = MODE_WORD;
         pstart_a = pos_ff;
      end
      pos_inc = sat_inc(pos_ff);
      kind_e  = paren_a ? KIND_PAREN : KIND_QUOTE;

      // End of input returns the scan state to its reset values
      if (req_end_of_input) begin
         mode_in   = MODE_BETWEEN;
         pos_in    = '0;
         pstart_in = '0;
         nl_in     = '0;
         paren_in  = 1'b0;
      end else begin
         mode_in   = mode_a;
         pos_in    = pos_inc;
         pstart_in = pstart_a;
         nl_in     = nl_a;
         paren_in  = paren_a;
      end
   end

   // Gather the results of this byte in order
   always_comb begin
      res = '0;
      n   = '0;
      if (close_word) begin
         res[n] = mk_res(EV_TOKEN, KIND_WORD, pstart_ff, pos_ff - pstart_ff, nl_ff);
         n      = n + 1'b1;
      end
      if (slash_split) begin
         res[n] = mk_res(EV_TOKEN, KIND_SPLIT, pstart_ff, POS_ONE, nl_ff);
         n      = n + 1'b1;
      end
      if (quote_close) begin
         res[n] = mk_res(EV_TOKEN, kind_q, pstart_ff, pos_ff - pstart_ff, nl_ff);
         n      = n + 1'b1;
      end
      if (quote_eol) begin
         res[n] = mk_res(EV_UNCLOSED_EOL, kind_q, pstart_ff, pos_ff - pstart_ff, nl_ff);
         n      = n + 1'b1;
      end
      if (start_split) begin
         res[n] = mk_res(EV_TOKEN, KIND_SPLIT, pos_ff, POS_ONE, nl_ff);
         n      = n + 1'b1;
      end
      if (req_end_of_input) begin
         if (mode_a == MODE_WORD) begin
            res[n] = mk_res(EV_TOKEN, KIND_WORD, pstart_a, pos_inc - pstart_a, nl_a);
            n      = n + 1'b1;
         end else if (mode_a == MODE_SLASH) begin
            res[n] = mk_res(EV_TOKEN, split_slash ? KIND_SPLIT : KIND_WORD,
                            pstart_a, POS_ONE, nl_a);
            n      = n + 1'b1;
         end else if (mode_a == MODE_QUOTE) begin
            res[n] = mk_res(EV_UNCLOSED_EOI, kind_e, pstart_a, pos_inc - pstart_a, nl_a);
            n      = n + 1'b1;
         end
         res[n] = mk_res(EV_END, KIND_WORD, pos_inc, '0, nl_a);
         n      = n + 1'b1;
      end
   end

   // Hand the bundle to the queue
   always_comb begin
      push.valid      = accept && (n != '0);
      push.bundle.cnt = n;
      push.bundle.res = res;
   end

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mask_lo_ff  <= '0;
         mask_hi_ff  <= '0;
         quote_en_ff <= 1'b0;
         paren_en_ff <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_SPLIT_LOW:  mask_lo_ff  <= csr_wdata;
            CSR_SPLIT_HIGH: mask_hi_ff  <= csr_wdata;
            CSR_QUOTES_EN:  quote_en_ff <= csr_wdata[0];
            CSR_PARENS_EN:  paren_en_ff <= csr_wdata[0];
            default:        mask_lo_ff  <= mask_lo_ff;
         endcase
      end
   end

   // Advance the scan state on each accepted item
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_BETWEEN;
         pos_ff    <= '0;
         pstart_ff <= '0;
         nl_ff     <= '0;
         paren_ff  <= 1'b0;
      end else if (accept) begin
         mode_ff   <= mode_in;
         pos_ff    <= pos_in;
         pstart_ff <= pstart_in;
         nl_ff     <= nl_in;
         paren_ff  <= paren_in;
      end
   end

endmodule

### rtl/txttok_queue.sv
// ---------------------------------------------------------------------------
// Tokenizer bundle queue
// Short first-in first-out queue of result bundles between front and back.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module txttok_queue import txttok_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  push_type   push,
   output logic       push_space,
   output head_type   head,
   input  logic       pop
);

   bundle_type          store_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ff, wr_in, rd_ff, rd_in;
   logic [QPTR_W:0]     count_ff, count_in;

   // Show the oldest bundle
   always_comb begin
      push_space  = (count_ff != (QPTR_W + 1)'(QUEUE_DEPTH));
      head.valid  = (count_ff != '0);
      head.bundle = store_ff[rd_ff];
   end

   // Advance pointers and fill count
   always_comb begin
      wr_in    = push.valid ? wr_ff + 1'b1 : wr_ff;
      rd_in    = pop ? rd_ff + 1'b1 : rd_ff;
      count_in = count_ff;
      if (push.valid && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push.valid && pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   // Store the incoming bundle
   always_ff @(posedge clock) begin
      if (push.valid) begin
         store_ff[wr_ff] <= push.bundle;
      end
   end

endmodule

### rtl/txttok_back.sv
// ---------------------------------------------------------------------------
// Tokenizer back end
// Takes bundles from the queue and sends their results one item per cycle while rsp_ready is high.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module txttok_back import txttok_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  head_type          head,
   output logic              pop,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [1:0]        rsp_event_res,
   output logic [1:0]        rsp_token_kind,
   output logic [TEXT_W-1:0] rsp_token_start,
   output logic [TEXT_W-1:0] rsp_token_length,
   output logic [TEXT_W-1:0] rsp_line_number,
   output logic              rsp_last_of_run
);

   bundle_type           cur_ff;
   logic                 have_ff, have_in;
   logic [RES_IDX_W-1:0] idx_ff, idx_in;
   logic                 fire, last, load;
   res_type              r;

   // Step through the held bundle, load the next one after its last item
   always_comb begin
      fire    = have_ff && rsp_ready;
      last    = (idx_ff == (cur_ff.cnt - 1'b1));
      load    = head.valid && (!have_ff || (fire && last));
      pop     = load;
      have_in = have_ff;
      idx_in  = idx_ff;
      if (load) begin
         have_in = 1'b1;
         idx_in  = '0;
      end else if (fire && last) begin
         have_in = 1'b0;
         idx_in  = '0;
      end else if (fire) begin
         idx_in  = idx_ff + 1'b1;
      end
   end

   // Drive the result channel from the held bundle
   always_comb begin
      r                = cur_ff.res[idx_ff];
      rsp_valid        = have_ff;
      rsp_event_res    = r.ev;
      rsp_token_kind   = r.kind;
      rsp_token_start  = r.start;
      rsp_token_length = r.len;
      rsp_line_number  = r.line;
      rsp_last_of_run  = last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         have_ff <= 1'b0;
         idx_ff  <= '0;
      end else begin
         have_ff <= have_in;
         idx_ff  <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         cur_ff <= head.bundle;
      end
   end

endmodule

### rtl/text_tokenizer.sv
// Throughput: one input byte per cycle while each byte yields at most one result;
//   the result port sends one item per cycle while rsp_ready is high, so bytes with
//   several results stall the input once the four-bundle queue fills.
// Path: the results of an accepted byte are written into the queue, then loaded
//   into the output stage, which offers them on rsp_valid.
// Reset: synchronous, clears scan state, configuration, queue and output stage.
// ---------------------------------------------------------------------------
// Text tokenizer
// Streaming tokenizer with split characters, quotes, parentheses and comments.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module text_tokenizer import txttok_pkg::*; #(
   parameter int POSITION_BITS = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_we,
   input  logic [1:0]        csr_index,
   input  logic [63:0]       csr_wdata,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [7:0]        req_in_byte,
   input  logic              req_end_of_input,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [1:0]        rsp_event_res,
   output logic [1:0]        rsp_token_kind,
   output logic [TEXT_W-1:0] rsp_token_start,
   output logic [TEXT_W-1:0] rsp_token_length,
   output logic [TEXT_W-1:0] rsp_line_number,
   output logic              rsp_last_of_run
);

   push_type push;
   head_type head;
   logic     push_space;
   logic     pop;

   // Scan and classify
   txttok_front #(
      .POSITION_BITS (POSITION_BITS)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_in_byte      (req_in_byte),
      .req_end_of_input (req_end_of_input),
      .push_space       (push_space),
      .push             (push)
   );

   // Decouple the two sides
   txttok_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_space (push_space),
      .head       (head),
      .pop        (pop)
   );

   // Send results
   txttok_back u_back (
      .clock            (clock),
      .reset            (reset),
      .head             (head),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_event_res    (rsp_event_res),
      .rsp_token_kind   (rsp_token_kind),
      .rsp_token_start  (rsp_token_start),
      .rsp_token_length (rsp_token_length),
      .rsp_line_number  (rsp_line_number),
      .rsp_last_of_run  (rsp_last_of_run)
   );

endmodule

### rtl/txttok_checker.sv
// ---------------------------------------------------------------------------
// Tokenizer port checker
// Watches the top-level ports of the tokenizer over time.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module txttok_checker import txttok_pkg::*; (
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic [1:0]        rsp_event_res,
   input logic [1:0]        rsp_token_kind,
   input logic [TEXT_W-1:0] rsp_token_start,
   input logic [TEXT_W-1:0] rsp_token_length,
   input logic [TEXT_W-1:0] rsp_line_number,
   input logic              rsp_last_of_run
);

   // A stalled result stays offered
   `TT_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid, "rsp dropped")

   // A stalled result keeps its payload
   `TT_ASSERT(a_rsp_stable, clock, reset,
              rsp_valid && !rsp_ready |=> $stable(rsp_token_start) &&
              $stable(rsp_token_length) && $stable(rsp_event_res) &&
              $stable(rsp_token_kind) && $stable(rsp_line_number) &&
              $stable(rsp_last_of_run), "rsp changed")

   // End of input always closes the run of its byte
   `TT_ASSERT(a_end_last, clock, reset,
              rsp_valid && (rsp_event_res == EV_END) |-> rsp_last_of_run, "end not last")

   // A split-character token is one character long
   `TT_ASSERT(a_split_len, clock, reset,
              rsp_valid && (rsp_event_res == EV_TOKEN) && (rsp_token_kind == KIND_SPLIT)
              |-> (rsp_token_length == 16'd1), "split length")

   // Nothing is offered right after reset
   `TT_ASSERT_ALWAYS(a_reset_idle, clock, reset |=> !rsp_valid, "rsp after reset")

endmodule

bind text_tokenizer txttok_checker u_txttok_checker (.*);
